// File: sv/wps_pkg.sv
// Shared types and constants for the LED pixel serializer.
`timescale 1ns / 1ps

package wps_pkg;

  localparam int PIX_BITS = 24;
  localparam int CFG_W    = 8;
  localparam int CFG_IDXW = 3;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_SHOW = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDXW-1:0] REG_PIXEL_COUNT = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_PERIOD      = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_HIGH_ONE    = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_HIGH_ZERO   = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_RESET_SLOTS = 3'd4;

  localparam logic [5:0] RST_PIXEL_COUNT = 6'd0;
  localparam logic [7:0] RST_PERIOD      = 8'd105;
  localparam logic [7:0] RST_HIGH_ONE    = 8'd67;
  localparam logic [7:0] RST_HIGH_ZERO   = 8'd34;
  localparam logic [7:0] RST_RESET_SLOTS = 8'd50;

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_COPY = 2'b10
  } state_t;

endpackage

// File: sv/ws2812_pixel_serializer.sv
// LED pixel serializer: pixel store, frame snapshot and bit-slot line timing.
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries commands: tuser = command (set pixel, show, tick, no-op),
//   tdata = pixel index and red/green/blue. Every request yields exactly one
//   result on the master stream: tdata = line level and busy flag, tlast = frame
//   done (tick ending the last slot, or a show with no pixels and no reset slots).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for pixel
//   count, slot period, one/zero high times and trailing reset slots; write it
//   only while no frame is in flight.
//   Set-pixel, tick and no-op requests are accepted one per clock while the output
//   register drains. A show that starts a frame copies the pixel store into the
//   send store, one entry per cycle through the pixel store's read port; its
//   result is issued as the last entry is written, and the slave side is held
//   off meanwhile.
//   During a frame the next pixel word is prefetched from the send store.
//   Reset clears the control state, the pixel store valid bits (unwritten
//   pixels read as zero) and restores the register defaults; no clearing pass.
//   If the receiver stalls, the single output register holds its result and
//   s_axis_tready drops until it is taken.
module ws2812_pixel_serializer #(
  parameter int MAX_PIXELS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // tdata: pixel_index[4:0], red[12:5], green[20:13], blue[28:21], zero pad
  input  logic [31:0]                   s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: line_level[0], busy_flag[1], zero pad
  output logic [7:0]                    m_axis_tdata,
  // tlast: frame_done
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we,
  input  logic [wps_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [wps_pkg::CFG_W-1:0]     cfg_data
);
  import wps_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);

  // configuration
  logic [5:0] pixel_count;
  logic [7:0] period_ticks;
  logic [7:0] high_ticks_one;
  logic [7:0] high_ticks_zero;
  logic [7:0] reset_slots;

  // stores
  pixel_t                  pixel_store [MAX_PIXELS];
  pixel_t                  send_store  [MAX_PIXELS];
  logic [MAX_PIXELS-1:0]   ps_valid;
  pixel_t                  ps_rd_data;
  pixel_t                  ss_rd_data;

  // frame state
  state_t        state;
  logic          sending, sending_next;
  logic [7:0]    tick_in_slot, tick_in_slot_next;
  logic [4:0]    bit_in_pixel, bit_in_pixel_next;
  logic [CW-1:0] pixel_position, pixel_position_next;
  logic [7:0]    reset_position, reset_position_next;
  logic          in_reset_phase, in_reset_phase_next;
  logic [CW-1:0] frame_pixels, frame_pixels_next;
  pixel_t        sh_word, sh_word_next;

  // snapshot copy
  logic [CW-1:0] copy_cnt;
  logic [AW-1:0] copy_addr;
  logic          copy_pend;
  logic          copy_vld;
  logic          show_level;
  pixel_t        copy_word;
  logic          copy_issue;
  logic          copy_last;

  // request decode
  logic          in_acc;
  cmd_t          cmd;
  logic [4:0]    pixel_index;
  pixel_t        new_pixel;
  logic [CW-1:0] active_pixels;
  logic          ps_we;
  logic          start_copy;
  logic          line_now;
  logic          level;
  logic          done;
  logic [AW-1:0] ss_rd_addr;

  assign cmd         = cmd_t'(s_axis_tuser);
  assign pixel_index = s_axis_tdata[4:0];
  // packed green, red, blue
  assign new_pixel   = {s_axis_tdata[20:13], s_axis_tdata[12:5], s_axis_tdata[28:21]};

  assign s_axis_tready = (state == S_RUN) && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (int'(pixel_count) > MAX_PIXELS) begin
      active_pixels = CW'(MAX_PIXELS);
    end else begin
      active_pixels = CW'(pixel_count);
    end
  end

  assign line_now = sending && !in_reset_phase &&
                    (tick_in_slot < (sh_word[PIX_BITS-1] ? high_ticks_one : high_ticks_zero));

  // prefetch the word after the current pixel
  always_comb begin
    if (int'(pixel_position) + 1 < MAX_PIXELS) begin
      ss_rd_addr = AW'(pixel_position + CW'(1));
    end else begin
      ss_rd_addr = AW'(pixel_position);
    end
  end

  assign copy_issue = (state == S_COPY) && (copy_cnt < frame_pixels);
  assign copy_word  = copy_vld ? ps_rd_data : '0;
  assign copy_last  = copy_pend && ((CW'(copy_addr) + CW'(1)) == frame_pixels);

  always_comb begin
    sending_next        = sending;
    tick_in_slot_next   = tick_in_slot;
    bit_in_pixel_next   = bit_in_pixel;
    pixel_position_next = pixel_position;
    reset_position_next = reset_position;
    in_reset_phase_next = in_reset_phase;
    frame_pixels_next   = frame_pixels;
    sh_word_next        = sh_word;
    level               = line_now;
    done                = 1'b0;
    start_copy          = 1'b0;
    ps_we               = 1'b0;
    if (in_acc) begin
      unique case (cmd)
        CMD_SET: begin
          if (int'(pixel_index) < int'(active_pixels)) begin
            ps_we = 1'b1;
          end
        end
        CMD_SHOW: begin
          if (!sending) begin
            frame_pixels_next   = active_pixels;
            tick_in_slot_next   = '0;
            bit_in_pixel_next   = '0;
            pixel_position_next = '0;
            reset_position_next = '0;
            level               = 1'b0;
            if (active_pixels == '0) begin
              if (reset_slots == '0) begin
                in_reset_phase_next = 1'b0;
                done                = 1'b1;
              end else begin
                in_reset_phase_next = 1'b1;
                sending_next        = 1'b1;
              end
            end else begin
              in_reset_phase_next = 1'b0;
              start_copy          = 1'b1;
            end
          end
        end
        CMD_TICK: begin
          if (sending) begin
            if (({1'b0, tick_in_slot} + 9'd1) >= {1'b0, period_ticks}) begin
              tick_in_slot_next = '0;
              if (!in_reset_phase) begin
                if (bit_in_pixel == 5'(PIX_BITS - 1)) begin
                  bit_in_pixel_next   = '0;
                  pixel_position_next = pixel_position + CW'(1);
                  sh_word_next        = ss_rd_data;
                  if (({1'b0, pixel_position} + (CW+1)'(1)) >= {1'b0, frame_pixels}) begin
                    in_reset_phase_next = 1'b1;
                    reset_position_next = '0;
                    done                = (reset_slots == '0);
                  end
                end else begin
                  bit_in_pixel_next = bit_in_pixel + 5'd1;
                  sh_word_next      = {sh_word[PIX_BITS-2:0], 1'b0};
                end
              end else if (({1'b0, reset_position} + 9'd1) >= {1'b0, reset_slots}) begin
                done = 1'b1;
              end else begin
                reset_position_next = reset_position + 8'd1;
              end
              if (done) begin
                sending_next        = 1'b0;
                in_reset_phase_next = 1'b0;
                bit_in_pixel_next   = '0;
                pixel_position_next = '0;
                reset_position_next = '0;
              end
            end else begin
              tick_in_slot_next = tick_in_slot + 8'd1;
            end
          end else begin
            level = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // pixel store port: write on set pixel, read for the snapshot sweep
  always_ff @(posedge clk) begin
    if (ps_we) begin
      pixel_store[AW'(pixel_index)] <= new_pixel;
    end
    ps_rd_data <= pixel_store[copy_cnt[AW-1:0]];
  end

  // send store: written by the sweep, read for the next-pixel prefetch
  always_ff @(posedge clk) begin
    if (copy_pend) begin
      send_store[copy_addr] <= copy_word;
    end
    ss_rd_data <= send_store[ss_rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count     <= RST_PIXEL_COUNT;
      period_ticks    <= RST_PERIOD;
      high_ticks_one  <= RST_HIGH_ONE;
      high_ticks_zero <= RST_HIGH_ZERO;
      reset_slots     <= RST_RESET_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_COUNT: pixel_count     <= cfg_data[5:0];
        REG_PERIOD:      period_ticks    <= cfg_data;
        REG_HIGH_ONE:    high_ticks_one  <= cfg_data;
        REG_HIGH_ZERO:   high_ticks_zero <= cfg_data;
        REG_RESET_SLOTS: reset_slots     <= cfg_data;
        default: ;
      endcase
    end
  end

  // word kept in the shift register across the sweep
  always_ff @(posedge clk) begin
    if (state == S_COPY) begin
      if (copy_pend && (copy_addr == '0)) begin
        sh_word    <= copy_word;
        show_level <= ((copy_word[PIX_BITS-1] ? high_ticks_one : high_ticks_zero) != '0);
      end
    end else begin
      sh_word <= sh_word_next;
    end
    if (copy_issue) begin
      copy_addr <= copy_cnt[AW-1:0];
      copy_vld  <= ps_valid[copy_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RUN;
      ps_valid       <= '0;
      sending        <= 1'b0;
      tick_in_slot   <= '0;
      bit_in_pixel   <= '0;
      pixel_position <= '0;
      reset_position <= '0;
      in_reset_phase <= 1'b0;
      frame_pixels   <= '0;
      copy_cnt       <= '0;
      copy_pend      <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      m_axis_tdata   <= '0;
      m_axis_tlast   <= 1'b0;
    end else begin
      if (ps_we) begin
        ps_valid[AW'(pixel_index)] <= 1'b1;
      end
      sending        <= sending_next;
      tick_in_slot   <= tick_in_slot_next;
      bit_in_pixel   <= bit_in_pixel_next;
      pixel_position <= pixel_position_next;
      reset_position <= reset_position_next;
      in_reset_phase <= in_reset_phase_next;
      frame_pixels   <= frame_pixels_next;

      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_RUN: begin
          if (start_copy) begin
            state     <= S_COPY;
            copy_cnt  <= '0;
            copy_pend <= 1'b0;
          end else if (in_acc) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, sending_next, level};
            m_axis_tlast  <= done;
          end
        end
        S_COPY: begin
          copy_pend <= copy_issue;
          if (copy_issue) begin
            copy_cnt <= copy_cnt + CW'(1);
          end
          if (copy_last) begin
            state         <= S_RUN;
            sending       <= 1'b1;
            copy_pend     <= 1'b0;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, 1'b1, show_level_now()};
            m_axis_tlast  <= 1'b0;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  // level of the first slot; forwarded when pixel 0 is written in the last cycle
  function automatic logic show_level_now();
    if (copy_addr == '0) begin
      return ((copy_word[PIX_BITS-1] ? high_ticks_one : high_ticks_zero) != '0);
    end
    return show_level;
  endfunction

endmodule

// File: tb/ws2812_pixel_serializer_test.sv
// Testbench for the LED pixel serializer: directed frames, random command streams, line checks.
`timescale 1ns / 1ps

module ws2812_pixel_serializer_test;
  import wps_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_WAIT     = 17;
  localparam int STALL_LIMIT  = 2000;
  localparam int LED_SLOTS    = 32;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } line_sample_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic [31:0]         s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = CMD_NOP;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [CFG_IDXW-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]    cfg_data      = '0;

  // shared between the sender, the result sink and the tests
  line_sample_t line_q[$];
  int           errors    = 0;
  int           hold_req  = 0;
  bit           pace_in   = 1'b1;
  bit           pace_out  = 1'b1;

  // predictor state
  pixel_t      led_mem [LED_SLOTS];
  pixel_t      led_snap[LED_SLOTS];
  logic        frame_active = 1'b0;
  logic [7:0]  slot_tick    = '0;
  logic [4:0]  bit_idx      = '0;
  logic [5:0]  pix_idx      = '0;
  logic [7:0]  gap_idx      = '0;
  logic        in_gap       = 1'b0;
  logic [5:0]  frame_len    = '0;
  logic [5:0]  cfg_count    = RST_PIXEL_COUNT;
  logic [7:0]  cfg_period   = RST_PERIOD;
  logic [7:0]  cfg_one      = RST_HIGH_ONE;
  logic [7:0]  cfg_zero     = RST_HIGH_ZERO;
  logic [7:0]  cfg_gap      = RST_RESET_SLOTS;

  ws2812_pixel_serializer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // level of the slot in progress, 0 when idle or in the trailing low slots
  function automatic logic slot_level();
    logic [7:0] cmp;
    pixel_t     word;
    cmp = '0;
    if (!frame_active) return 1'b0;
    if (!in_gap && pix_idx < LED_SLOTS && bit_idx < PIX_BITS) begin
      word = led_snap[pix_idx];
      cmp  = word[PIX_BITS - 1 - bit_idx] ? cfg_one : cfg_zero;
    end
    return slot_tick < cmp;
  endfunction

  // closes the current slot; returns 1 when the frame is over
  function automatic logic advance_slot();
    slot_tick = '0;
    if (!in_gap) begin
      bit_idx++;
      if (bit_idx >= PIX_BITS) begin
        bit_idx = '0;
        pix_idx++;
        if (pix_idx >= frame_len) begin
          in_gap  = 1'b1;
          gap_idx = '0;
          return cfg_gap == 0;
        end
      end
      return 1'b0;
    end
    if (gap_idx + 1 >= cfg_gap) return 1'b1;
    gap_idx++;
    return 1'b0;
  endfunction

  function automatic line_sample_t predict_line(input cmd_t cmd, input logic [4:0] idx,
                                                input logic [7:0] red, green, blue);
    line_sample_t s;
    logic [5:0]   live;
    s    = '0;
    live = (cfg_count > LED_SLOTS) ? 6'(LED_SLOTS) : cfg_count;
    case (cmd)
      CMD_SET: begin
        if (idx < live) led_mem[idx] = {green, red, blue};
        s.level = slot_level();
      end
      CMD_SHOW: begin
        if (!frame_active) begin
          led_snap  = led_mem;
          frame_len = live;
          slot_tick = '0;
          bit_idx   = '0;
          pix_idx   = '0;
          gap_idx   = '0;
          in_gap    = (live == 0);
          if (in_gap && cfg_gap == 0) begin
            in_gap = 1'b0;
            s.done = 1'b1;
          end else begin
            frame_active = 1'b1;
          end
        end
        s.level = slot_level();
      end
      CMD_TICK: begin
        if (frame_active) begin
          s.level = slot_level();
          if (slot_tick + 1 >= cfg_period) begin
            if (advance_slot()) begin
              frame_active = 1'b0;
              in_gap       = 1'b0;
              slot_tick    = '0;
              bit_idx      = '0;
              pix_idx      = '0;
              gap_idx      = '0;
              s.done       = 1'b1;
            end
          end else begin
            slot_tick++;
          end
        end
      end
      default: begin
        s.level = slot_level();
      end
    endcase
    s.busy = frame_active;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    line_sample_t want;
    line_sample_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast};
      if (line_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result: expected none, actual level=%0b busy=%0b done=%0b",
                   $time, got.level, got.busy, got.done);
      end else begin
        want = line_q.pop_front();
        check_field("line_level", want.level, got.level);
        check_field("busy_flag", want.busy, got.busy);
        check_field("frame_done", want.done, got.done);
      end
    end
  end

  // result sink: random stalls, plus a long hold-off when a test asks for one
  initial begin : result_sink
    int wait_cycles;
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = pace_out ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold_req > 0) begin
        wait_cycles = hold_req;
        hold_req    = 0;
      end
      @(negedge clk);
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(input cmd_t cmd, input logic [4:0] idx,
                              input logic [7:0] red, green, blue);
    int wait_cycles;
    wait_cycles = pace_in ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (wait_cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    s_axis_tdata  <= {3'b000, blue, green, red, idx};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    line_q.push_back(predict_line(cmd, idx, red, green, blue));
  endtask

  task automatic send_noise(input cmd_t cmd);
    send_request(cmd, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // tick the frame out, drop valid and drain every expected result
  task automatic quiesce();
    while (frame_active) send_noise(CMD_TICK);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PIXEL_COUNT: cfg_count  = val[5:0];
      REG_PERIOD:      cfg_period = val;
      REG_HIGH_ONE:    cfg_one    = val;
      REG_HIGH_ZERO:   cfg_zero   = val;
      REG_RESET_SLOTS: cfg_gap    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_timing(input logic [5:0] count, input logic [7:0] period,
                                input logic [7:0] one, zero, gap);
    quiesce();
    write_reg(REG_PIXEL_COUNT, {2'b00, count});
    write_reg(REG_PERIOD, period);
    write_reg(REG_HIGH_ONE, one);
    write_reg(REG_HIGH_ZERO, zero);
    write_reg(REG_RESET_SLOTS, gap);
  endtask

  // one pixel with the other registers at their reset values
  task automatic test_reset_defaults();
    pace_in  = 1'b0;
    pace_out = 1'b0;
    send_noise(CMD_NOP);
    send_request(CMD_SET, 5'd0, 8'hFF, 8'hFF, 8'hFF);  // ignored, count is 0
    send_noise(CMD_TICK);
    quiesce();
    write_reg(REG_PIXEL_COUNT, 8'd1);
    send_request(CMD_SET, 5'd0, 8'h81, 8'hC3, 8'h5A);
    send_noise(CMD_SHOW);
    quiesce();
  endtask

  task automatic test_pixel_store();
    pace_in  = 1'b1;
    pace_out = 1'b1;
    program_timing(6'd4, 8'd3, 8'd2, 8'd1, 8'd2);
    send_request(CMD_SET, 5'd0, 8'hFF, 8'hFF, 8'hFF);
    send_request(CMD_SET, 5'd1, 8'h00, 8'h00, 8'h00);
    send_request(CMD_SET, 5'd2, 8'h55, 8'hAA, 8'hF0);
    send_request(CMD_SET, 5'd3, 8'h80, 8'h01, 8'h7E);
    send_request(CMD_SET, 5'd4, 8'h12, 8'h34, 8'h56);  // at count: dropped
    send_request(CMD_SET, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    send_noise(CMD_SHOW);
    repeat (5) send_noise(CMD_TICK);
    // store write while the snapshot goes out
    send_request(CMD_SET, 5'd1, 8'hFF, 8'h0F, 8'hF0);
    send_noise(CMD_SHOW);
    send_noise(CMD_NOP);
    quiesce();
    send_noise(CMD_SHOW);
    quiesce();
  endtask

  task automatic test_empty_frame();
    program_timing(6'd0, 8'd4, 8'd2, 8'd1, 8'd0);
    send_noise(CMD_SHOW);
    send_noise(CMD_SHOW);
    send_noise(CMD_TICK);
    program_timing(6'd0, 8'd4, 8'd2, 8'd1, 8'd1);
    send_noise(CMD_SHOW);
    quiesce();
  endtask

  task automatic test_slot_extremes();
    // period 0 and a count past the store size
    program_timing(6'd63, 8'd0, 8'd1, 8'd0, 8'd3);
    for (int i = 0; i < LED_SLOTS; i++)
      send_request(CMD_SET, 5'(i), 8'($urandom), 8'($urandom), 8'($urandom));
    send_noise(CMD_SHOW);
    quiesce();
    program_timing(6'd2, 8'd1, 8'd255, 8'd0, 8'd1);
    send_noise(CMD_SHOW);
    quiesce();
    pace_in  = 1'b0;
    pace_out = 1'b0;
    program_timing(6'd1, 8'd255, 8'd255, 8'd254, 8'd1);
    send_noise(CMD_SHOW);
    quiesce();
    program_timing(6'd0, 8'd2, 8'd0, 8'd255, 8'd255);
    send_noise(CMD_SHOW);
    quiesce();
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_backpressure();
    pace_in  = 1'b0;
    pace_out = 1'b1;
    program_timing(6'd2, 8'd4, 8'd3, 8'd1, 8'd2);
    send_noise(CMD_SHOW);
    hold_req = 300;
    repeat (40) send_noise(CMD_TICK);
    quiesce();
  endtask

  task automatic test_random_frames();
    int         sent;
    int         pick;
    logic [5:0] count;
    logic [7:0] period;
    logic [7:0] one;
    logic [7:0] zero;
    logic [7:0] gap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pace_in  = $urandom_range(0, 3) != 0;
      pace_out = $urandom_range(0, 3) != 0;
      count  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
      if (count > 4)
        period = 8'($urandom_range(0, 3));
      else
        period = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                             : 8'($urandom_range(0, 6));
      one  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, period + 2));
      zero = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, period + 2));
      gap  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 60)) : 8'($urandom_range(0, 4));
      program_timing(count, period, one, zero, gap);
      repeat ($urandom_range(0, 6)) begin
        send_noise(CMD_SET);
        sent++;
      end
      // now and then no show: sets and ticks against an idle line
      if ($urandom_range(0, 6) != 0) begin
        send_noise(CMD_SHOW);
        sent++;
      end
      while (frame_active) begin
        pick = $urandom_range(0, 99);
        if (pick < 82) send_noise(CMD_TICK);
        else if (pick < 90) send_noise(CMD_SET);
        else if (pick < 95) send_noise(CMD_NOP);
        else send_noise(CMD_SHOW);
        if (pick < 90 || pick >= 95) sent++;
      end
      repeat ($urandom_range(0, 3)) begin
        send_noise(cmd_t'($urandom_range(0, 3)));
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < LED_SLOTS; i++) begin
      led_mem[i]  = '0;
      led_snap[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_pixel_store();
    test_empty_frame();
    test_slot_extremes();
    test_backpressure();
    test_random_frames();
    quiesce();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
sv/wps_pkg.sv
sv/ws2812_pixel_serializer.sv
tb/ws2812_pixel_serializer_test.sv
